// ----- design/fsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types, constants and helpers for the frame sync / CRC check block.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;
    localparam int MARKER_BYTES        = 4;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [7:0] MARKER [MARKER_BYTES] = '{8'h1a, 8'hcf, 8'hfc, 8'h1d};

    localparam logic [15:0] CRC_INIT = 16'hffff;
    localparam logic [15:0] CNT_MAX  = 16'hffff;

    localparam logic [4:0]  HEADER_BYTES_RST = 5'd6;
    localparam logic [15:0] FRAME_LEN_M1_RST = 16'd1114;
    localparam logic        FECF_ENABLE_RST  = 1'b1;

    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_FORCE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] CFG_HEADER_BYTES = 2'd0;
    localparam logic [1:0] CFG_FRAME_LEN_M1 = 2'd1;
    localparam logic [1:0] CFG_FECF_ENABLE  = 2'd2;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_FORCE,
        KIND_CLEAR,
        KIND_NONE
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                data;
        logic [MARKER_BYTES-1:0]   marker_hit;
    } item_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  frame_byte;
        logic [10:0] byte_position;
        logic        frame_end;
        logic        frame_good;
        logic        overflow_seen;
        logic [15:0] sync_error_total;
        logic [15:0] crc_error_total;
        logic [15:0] overflow_error_total;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            fb = b[7-k] ^ c[15];
            c  = {c[14:0], 1'b0} ^ {3'b000, fb, 6'b000000, fb, 4'b0000, fb};
        end
        return c;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v != CNT_MAX) ? v + 16'd1 : v;
    endfunction

endpackage

// ----- design/fsc_front.sv -----
// ----------------------------------------------------------------------------
// fsc_front
// Input side: decodes the request type and precomputes marker byte matches.
// ----------------------------------------------------------------------------
module fsc_front (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic [1:0]       s_tuser,
    output logic             push_valid,
    input  logic             push_ready,
    output fsc_pkg::item_t   push_item
);
    import fsc_pkg::*;

    always_comb begin
        push_item.data = s_tdata;
        for (int k = 0; k < MARKER_BYTES; k++) begin
            push_item.marker_hit[k] = (s_tdata == MARKER[k]);
        end
        unique case (s_tuser)
            REQ_DATA:  push_item.kind = KIND_DATA;
            REQ_FORCE: push_item.kind = KIND_FORCE;
            REQ_CLEAR: push_item.kind = KIND_CLEAR;
            default:   push_item.kind = KIND_NONE;
        endcase
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

// ----- design/fsc_queue.sv -----
// ----------------------------------------------------------------------------
// fsc_queue
// Short FIFO of classified words between the front and back sections.
// ----------------------------------------------------------------------------
module fsc_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  fsc_pkg::item_t   push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output fsc_pkg::item_t   pop_item
);
    import fsc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/fsc_back.sv -----
// ----------------------------------------------------------------------------
// fsc_back
// Frame state: marker hunt, length latch, CRC check, error counters and
// the registered result word.
// ----------------------------------------------------------------------------
module fsc_back #(
    parameter int MAX_FRAME_BYTES = fsc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  fsc_pkg::item_t    pop_item,
    output logic              out_valid,
    input  logic              out_ready,
    output fsc_pkg::result_t  out_result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import fsc_pkg::*;

    localparam int LW  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int TWC = $clog2(MAX_FRAME_BYTES + 33);
    localparam int TW  = (TWC > 11) ? TWC : 11;
    localparam logic [16:0] MAX17 = 17'(MAX_FRAME_BYTES);

    logic [4:0]    header_reg;
    logic [15:0]   flm1_reg;
    logic          fecf_reg;

    logic          in_frame_reg, in_frame_next;
    logic [1:0]    mark_idx_reg, mark_idx_next;
    logic [TW-1:0] taken_reg, taken_next;
    logic          in_sync_reg, in_sync_next;
    logic          len_set_reg, len_set_next;
    logic [LW-1:0] len_reg, len_next;
    logic [15:0]   crc_reg, crc_next;
    logic [15:0]   last2_reg, last2_next;
    logic [15:0]   sync_cnt_reg, sync_cnt_next;
    logic [15:0]   crc_cnt_reg, crc_cnt_next;
    logic [15:0]   ovf_cnt_reg, ovf_cnt_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic          step, hit, hunt, framed, complete, start;
    logic          latch_due, drop, len_set_after, fin, good;
    logic [TW-1:0] taken_inc, taken_chk, eff, len_ext, hdr_ext;
    logic [LW-1:0] len_cfg, len_after;
    logic [15:0]   crc_upd, crc_new, last2_new;

    assign cfg_ready = 1'b1;
    assign pop_ready = !out_valid_reg || out_ready;
    assign step      = pop_valid && pop_ready;

    always_comb begin
        hit       = pop_item.marker_hit[mark_idx_reg];
        hunt      = (pop_item.kind == KIND_DATA) && !in_frame_reg;
        framed    = (pop_item.kind == KIND_DATA) && in_frame_reg;
        complete  = hunt && hit && (mark_idx_reg == 2'd3);
        start     = (pop_item.kind == KIND_FORCE) || complete;
        taken_inc = taken_reg + TW'(1);
        taken_chk = start ? '0 : taken_inc;
        hdr_ext   = TW'(header_reg);
        crc_upd   = crc_byte(crc_reg, last2_reg[15:8]);
        crc_new   = (taken_reg >= TW'(2)) ? crc_upd : crc_reg;
        last2_new = {last2_reg[7:0], pop_item.data};
        len_cfg   = LW'({1'b0, flm1_reg} + 17'd1);
        latch_due = (start || (framed && !len_set_reg)) && (taken_chk >= hdr_ext);
        drop      = latch_due && ({1'b0, flm1_reg} >= MAX17);
        len_after = latch_due ? len_cfg : len_reg;
        len_set_after = len_set_reg || latch_due;
        len_ext   = TW'(len_after);
        eff       = (len_ext > hdr_ext) ? len_ext : hdr_ext;
        fin       = framed && !drop && len_set_after && (taken_inc >= eff);
        good      = !fecf_reg || ((eff >= TW'(2)) && (crc_new == last2_new));
    end

    always_comb begin
        in_frame_next  = in_frame_reg;
        mark_idx_next  = mark_idx_reg;
        taken_next     = taken_reg;
        in_sync_next   = in_sync_reg;
        len_set_next   = len_set_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        last2_next     = last2_reg;
        sync_cnt_next  = sync_cnt_reg;
        crc_cnt_next   = crc_cnt_reg;
        ovf_cnt_next   = ovf_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        if (step) begin
            out_valid_next         = 1'b1;
            out_next.byte_valid    = 1'b0;
            out_next.frame_byte    = '0;
            out_next.byte_position = '0;
            out_next.frame_end     = 1'b0;
            out_next.frame_good    = 1'b0;
            out_next.overflow_seen = 1'b0;

            unique case (pop_item.kind)
                KIND_CLEAR: begin
                    sync_cnt_next = '0;
                    crc_cnt_next  = '0;
                    ovf_cnt_next  = '0;
                end
                KIND_FORCE, KIND_DATA: begin
                    if (hunt && !complete) begin
                        if (hit) begin
                            mark_idx_next = mark_idx_reg + 2'd1;
                        end else begin
                            in_sync_next  = 1'b0;
                            mark_idx_next = pop_item.marker_hit[0] ? 2'd1 : 2'd0;
                        end
                    end
                    if (start) begin
                        if (complete && !in_sync_reg) begin
                            sync_cnt_next = sat_inc(sync_cnt_reg);
                        end
                        in_frame_next = 1'b1;
                        taken_next    = '0;
                        in_sync_next  = 1'b1;
                        len_set_next  = 1'b0;
                        crc_next      = CRC_INIT;
                        last2_next    = '0;
                    end
                    if (framed) begin
                        out_next.byte_valid    = 1'b1;
                        out_next.frame_byte    = pop_item.data;
                        out_next.byte_position = taken_reg[10:0];
                        taken_next             = taken_inc;
                        crc_next               = crc_new;
                        last2_next             = last2_new;
                    end
                    if (latch_due && !drop) begin
                        len_set_next = 1'b1;
                        len_next     = len_cfg;
                    end
                    if (drop) begin
                        out_next.overflow_seen = 1'b1;
                        in_sync_next  = 1'b0;
                        in_frame_next = 1'b0;
                        mark_idx_next = '0;
                        len_set_next  = 1'b0;
                        ovf_cnt_next  = sat_inc(ovf_cnt_reg);
                    end
                    if (fin) begin
                        out_next.frame_end  = 1'b1;
                        out_next.frame_good = good;
                        if (!good) begin
                            crc_cnt_next = sat_inc(crc_cnt_reg);
                        end
                        in_frame_next = 1'b0;
                        mark_idx_next = '0;
                        len_set_next  = 1'b0;
                    end
                end
                default: begin
                end
            endcase

            out_next.sync_error_total = sync_cnt_next
                + 16'((sync_cnt_next != CNT_MAX) && !in_sync_next);
            out_next.crc_error_total      = crc_cnt_next;
            out_next.overflow_error_total = ovf_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_BYTES_RST;
            flm1_reg   <= FRAME_LEN_M1_RST;
            fecf_reg   <= FECF_ENABLE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_HEADER_BYTES: header_reg <= cfg_data[4:0];
                CFG_FRAME_LEN_M1: flm1_reg   <= cfg_data;
                CFG_FECF_ENABLE:  fecf_reg   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            mark_idx_reg  <= '0;
            taken_reg     <= '0;
            in_sync_reg   <= 1'b1;
            len_set_reg   <= 1'b0;
            len_reg       <= '0;
            crc_reg       <= CRC_INIT;
            last2_reg     <= '0;
            sync_cnt_reg  <= '0;
            crc_cnt_reg   <= '0;
            ovf_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_frame_reg  <= in_frame_next;
            mark_idx_reg  <= mark_idx_next;
            taken_reg     <= taken_next;
            in_sync_reg   <= in_sync_next;
            len_set_reg   <= len_set_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            last2_reg     <= last2_next;
            sync_cnt_reg  <= sync_cnt_next;
            crc_cnt_reg   <= crc_cnt_next;
            ovf_cnt_reg   <= ovf_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    ap_len_only_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        len_set_reg |-> in_frame_reg)
        else $error("length latched outside a frame");

    ap_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_set_reg |-> (len_reg != '0) && (TW'(len_reg) <= TW'(MAX_FRAME_BYTES)))
        else $error("latched length out of range");

    ap_end_is_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.frame_end || out_reg.frame_good) |->
            out_reg.byte_valid && out_reg.frame_end)
        else $error("frame end flags without a frame byte");

endmodule

// ----- design/frame_sync_crc_check.sv -----
// ----------------------------------------------------------------------------
// frame_sync_crc_check
// Byte stream frame synchronizer (marker 1ACFFC1D) with CRC-16 FECF check.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  tdata: data_byte | tuser: req_type
//   m_       out  m_tvalid/m_tready  tdata: byte, position, totals
//                                    tuser: flags | tlast: frame_end
//   cfg_     in   cfg_valid/ready    cfg_index, cfg_data
//
// One word in per cycle sustained while neither side stalls; every input word yields one output word.
// A result reaches m_ through the queue write and then the output register;
// a stall on m_ can hold it in the queue.
// Marker byte compares sit in the front end; the byte-wide CRC update is combinational in the back end.
// A two-word queue decouples input and output stalls; s_tready drops only
// when the queue is full. Reset is synchronous.
// ----------------------------------------------------------------------------
module frame_sync_crc_check #(
    parameter int MAX_FRAME_BYTES = fsc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] frame_byte, [18:8] byte_position,
                                   // [34:19] sync_error_total,
                                   // [50:35] crc_error_total,
                                   // [66:51] overflow_error_total, rest zero
    output logic [2:0]  m_tuser,   // [0] byte_valid, [1] frame_good, [2] overflow_seen
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fsc_pkg::*;

    logic    push_valid, push_ready, pop_valid, pop_ready;
    item_t   push_item, pop_item;
    result_t res;

    fsc_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fsc_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    assign m_tdata = {5'b00000, res.overflow_error_total, res.crc_error_total,
                      res.sync_error_total, res.byte_position, res.frame_byte};
    assign m_tuser = {res.overflow_seen, res.frame_good, res.byte_valid};
    assign m_tlast = res.frame_end;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives frame_sync_crc_check with byte words, forced-sync and counter-clear
// requests, and compares every output word against a cycle-free predictor of
// the marker hunt, length latch, overflow drop, CRC-16 FECF check and the
// saturating error totals. Both sides stall at random; one long sink hold-off
// fills the block so it stalls its input.
// ----------------------------------------------------------------------------
module testbench;
    import fsc_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int MAX_LEN      = MAX_FRAME_BYTES_DEF;
    localparam int RANDOM_WORDS = 500;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    frame_sync_crc_check u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor configuration and state
    logic [4:0]  hdr_bytes;
    logic [15:0] len_m1;
    logic        fecf_on;
    logic [16:0] hunt_pos;
    logic        locked;
    logic [16:0] frame_len;
    logic [15:0] crc_acc;
    logic [15:0] tail_bytes;
    logic [15:0] sync_err_cnt;
    logic [15:0] crc_err_cnt;
    logic [15:0] ovf_err_cnt;

    result_t     outputs_due[$];
    int          err_count   = 0;
    int          cycle_count = 0;
    int          words_sent  = 0;
    int          sink_hold   = 0;
    bit          src_burst   = 1'b0;
    bit          sink_burst  = 1'b0;

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
        for (int i = 7; i >= 0; i--) begin
            if (crc[15] ^ b[i]) crc = {crc[14:0], 1'b0} ^ 16'h1021;
            else crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

    function automatic logic [15:0] count_up(logic [15:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic void open_frame();
        hunt_pos   = 17'(MARKER_BYTES);
        locked     = 1'b1;
        frame_len  = '0;
        crc_acc    = CRC_INIT;
        tail_bytes = '0;
    endfunction

    // 1 when the frame is dropped for excess length
    function automatic bit latch_length();
        logic [16:0] want_len;
        want_len = {1'b0, len_m1} + 17'd1;
        if (frame_len == 0 && hunt_pos - MARKER_BYTES >= hdr_bytes) begin
            if (want_len > MAX_LEN) begin
                locked      = 1'b0;
                hunt_pos    = '0;
                frame_len   = '0;
                ovf_err_cnt = count_up(ovf_err_cnt);
                return 1'b1;
            end
            frame_len = want_len;
        end
        return 1'b0;
    endfunction

    function automatic result_t predict_word(kind_t kind, logic [7:0] b);
        result_t     r;
        logic [16:0] idx;
        logic [16:0] eff;
        bit          good;
        r = '0;
        case (kind)
            KIND_CLEAR: begin
                sync_err_cnt = '0;
                crc_err_cnt  = '0;
                ovf_err_cnt  = '0;
            end
            KIND_FORCE: begin
                open_frame();
                r.overflow_seen = latch_length();
            end
            KIND_DATA: begin
                if (hunt_pos < MARKER_BYTES) begin
                    if (b == MARKER[hunt_pos[1:0]]) begin
                        hunt_pos++;
                    end else begin
                        locked   = 1'b0;
                        hunt_pos = (b == MARKER[0]) ? 17'd1 : 17'd0;
                    end
                    if (hunt_pos == MARKER_BYTES) begin
                        if (!locked) sync_err_cnt = count_up(sync_err_cnt);
                        open_frame();
                        r.overflow_seen = latch_length();
                    end
                end else begin
                    idx             = 17'(hunt_pos - MARKER_BYTES);
                    r.byte_valid    = 1'b1;
                    r.frame_byte    = b;
                    r.byte_position = idx[10:0];
                    if (idx >= 2) crc_acc = crc16_feed(crc_acc, tail_bytes[15:8]);
                    tail_bytes = {tail_bytes[7:0], b};
                    hunt_pos++;
                    if (latch_length()) begin
                        r.overflow_seen = 1'b1;
                    end else if (frame_len != 0) begin
                        eff = (frame_len > hdr_bytes) ? frame_len : {12'd0, hdr_bytes};
                        if (idx + 1 >= eff) begin
                            good = !fecf_on || (eff >= 2 && crc_acc == tail_bytes);
                            if (!good) crc_err_cnt = count_up(crc_err_cnt);
                            r.frame_end  = 1'b1;
                            r.frame_good = good;
                            hunt_pos     = '0;
                            frame_len    = '0;
                        end
                    end
                end
            end
            KIND_NONE: ;
        endcase
        r.sync_error_total = sync_err_cnt +
                             ((!locked && sync_err_cnt != CNT_MAX) ? 16'd1 : 16'd0);
        r.crc_error_total      = crc_err_cnt;
        r.overflow_error_total = ovf_err_cnt;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
        $display("%0t ns: %s expected %h got %h", $time, what, want, got);
        err_count++;
    endtask

    task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
        if (got !== want) report_mismatch(what, want, got);
    endtask

    always @(posedge aclk) begin : check_outputs
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outputs_due.size() == 0) begin
                report_mismatch("unexpected word", 16'd0, 16'd1);
            end else begin
                want = outputs_due.pop_front();
                check_field("byte_valid", 16'(m_tuser[0]), 16'(want.byte_valid));
                check_field("frame_good", 16'(m_tuser[1]), 16'(want.frame_good));
                check_field("overflow_seen", 16'(m_tuser[2]), 16'(want.overflow_seen));
                check_field("frame_end", 16'(m_tlast), 16'(want.frame_end));
                check_field("frame_byte", 16'(m_tdata[7:0]), 16'(want.frame_byte));
                check_field("byte_position", 16'(m_tdata[18:8]),
                            16'(want.byte_position));
                check_field("sync_error_total", m_tdata[34:19], want.sync_error_total);
                check_field("crc_error_total", m_tdata[50:35], want.crc_error_total);
                check_field("overflow_error_total", m_tdata[66:51],
                            want.overflow_error_total);
                check_field("tdata pad", 16'(m_tdata[71:67]), 16'd0);
            end
        end
    end

    // sink: random stalls per word, plus an optional long hold-off
    initial begin : sink
        int stall;
        forever begin
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            stall = sink_burst ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_word(kind_t kind, logic [7:0] b);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        outputs_due.push_back(predict_word(kind, b));
        if (kind != KIND_NONE) words_sent++;
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] value);
        drain_outputs();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (index)
            CFG_HEADER_BYTES: hdr_bytes = value[4:0];
            CFG_FRAME_LEN_M1: len_m1    = value;
            CFG_FECF_ENABLE:  fecf_on   = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [4:0] hdr, logic [15:0] len, logic fecf);
        write_reg(CFG_HEADER_BYTES, {11'd0, hdr});
        write_reg(CFG_FRAME_LEN_M1, len);
        write_reg(CFG_FECF_ENABLE, {15'd0, fecf});
    endtask

    // one frame sized for the current settings, random body, FECF correct
    // unless spoiled; a cut frame stops early and stays open
    task automatic send_frame(bit by_marker, bit spoil, bit cut);
        logic [15:0] crc;
        logic [7:0]  b;
        int          want;
        int          n_bytes;
        want = int'(len_m1) + 1;
        if (want > MAX_LEN) n_bytes = int'(hdr_bytes);
        else n_bytes = (want > hdr_bytes) ? want : int'(hdr_bytes);
        if (cut && n_bytes > 1) n_bytes = $urandom_range(1, n_bytes - 1);
        if (by_marker) begin
            for (int i = 0; i < MARKER_BYTES; i++) send_word(KIND_DATA, MARKER[i]);
        end else begin
            send_word(KIND_FORCE, 8'($urandom_range(0, 255)));
        end
        crc = CRC_INIT;
        for (int i = 0; i < n_bytes; i++) begin
            if (i < n_bytes - 2) begin
                b   = 8'($urandom_range(0, 255));
                crc = crc16_feed(crc, b);
            end else if (i == n_bytes - 2) begin
                b = crc[15:8];
            end else begin
                b = crc[7:0] ^ (spoil ? 8'h01 << $urandom_range(0, 7) : 8'h00);
            end
            send_word(KIND_DATA, b);
        end
    endtask

    task automatic test_marker_hunt();
        send_word(KIND_DATA, 8'hcf);
        send_word(KIND_DATA, MARKER[0]);
        send_word(KIND_DATA, MARKER[0]);
        send_word(KIND_DATA, MARKER[1]);
        send_word(KIND_DATA, MARKER[2]);
        send_word(KIND_DATA, MARKER[3]);
        send_word(KIND_DATA, 8'hff);
        send_word(KIND_DATA, 8'h00);
        send_word(KIND_DATA, 8'ha5);
        send_word(KIND_NONE, 8'hff);
        send_word(KIND_CLEAR, 8'h00);
    endtask

    task automatic test_short_frames();
        set_config(5'd0, 16'd0, 1'b1);
        send_word(KIND_FORCE, 8'h00);
        send_word(KIND_DATA, 8'h5a);
        write_reg(CFG_FECF_ENABLE, 16'd0);
        send_word(KIND_FORCE, 8'h00);
        send_word(KIND_DATA, 8'hc3);
    endtask

    task automatic test_length_limits();
        set_config(5'd0, 16'd2048, 1'b1);
        send_word(KIND_FORCE, 8'h00);
        set_config(5'd2, 16'hffff, 1'b1);
        send_word(KIND_FORCE, 8'h00);
        send_word(KIND_DATA, 8'h11);
        send_word(KIND_DATA, 8'h22);
        set_config(5'd1, 16'd2047, 1'b0);
        send_word(KIND_FORCE, 8'h00);
        send_word(KIND_DATA, 8'h33);
        send_word(KIND_FORCE, 8'h00);
        send_word(KIND_DATA, 8'h44);
    endtask

    task automatic test_fecf_frames();
        set_config(5'd4, 16'd2, 1'b1);
        send_frame(1'b0, 1'b0, 1'b0);
        send_frame(1'b1, 1'b1, 1'b0);
        // header size lowered while a frame is open
        set_config(5'd16, 16'd4, 1'b1);
        send_word(KIND_FORCE, 8'h00);
        repeat (2) send_word(KIND_DATA, 8'($urandom_range(0, 255)));
        write_reg(CFG_HEADER_BYTES, 16'd1);
        repeat (3) send_word(KIND_DATA, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_backpressure();
        set_config(5'd2, 16'd11, 1'b1);
        src_burst = 1'b1;
        sink_hold = 400;
        send_frame(1'b0, 1'b0, 1'b0);
        repeat (3) send_frame(1'b1, 1'b0, 1'b0);
        drain_outputs();
        src_burst = 1'b0;
    endtask

    task automatic test_random_traffic();
        int         goal;
        bit         cut;
        bit         cut_prev;
        logic [4:0] hdr;
        logic [15:0] len;
        goal     = words_sent + RANDOM_WORDS;
        cut_prev = 1'b0;
        while (words_sent < goal) begin
            case ($urandom_range(0, 5))
                0:       hdr = 5'd0;
                1:       hdr = 5'd1;
                2:       hdr = 5'd16;
                3:       hdr = 5'd31;
                default: hdr = 5'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 9))
                0:       len = 16'hffff;
                1:       len = 16'($urandom_range(2048, 65534));
                2:       len = 16'd0;
                default: len = 16'($urandom_range(1, 40));
            endcase
            set_config(hdr, len, 1'($urandom_range(0, 1)));
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 5)) begin
                if (!cut_prev && $urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 1))
                            send_word(KIND_DATA, MARKER[$urandom_range(0, 3)]);
                        else
                            send_word(KIND_DATA, 8'($urandom_range(0, 255)));
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    send_word(KIND_CLEAR, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 15) == 0)
                    send_word(KIND_NONE, 8'($urandom_range(0, 255)));
                cut = ($urandom_range(0, 7) == 0);
                send_frame(!cut_prev && $urandom_range(0, 2) != 0,
                           $urandom_range(0, 3) == 0, cut);
                cut_prev = cut;
            end
        end
        src_burst  = 1'b0;
        sink_burst = 1'b0;
    endtask

    initial begin
        hdr_bytes    = HEADER_BYTES_RST;
        len_m1       = FRAME_LEN_M1_RST;
        fecf_on      = FECF_ENABLE_RST;
        hunt_pos     = '0;
        locked       = 1'b1;
        frame_len    = '0;
        crc_acc      = CRC_INIT;
        tail_bytes   = '0;
        sync_err_cnt = '0;
        crc_err_cnt  = '0;
        ovf_err_cnt  = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_marker_hunt();
        test_short_frames();
        test_length_limits();
        test_fecf_frames();
        test_backpressure();
        test_random_traffic();
        drain_outputs();
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ----- frame_sync_crc_check.f -----
design/fsc_pkg.sv
design/fsc_front.sv
design/fsc_queue.sv
design/fsc_back.sv
design/frame_sync_crc_check.sv
dv/testbench.sv
